### sv/arfp_pkg.sv
// Package for the API frame receive parser.
// Holds the frame layout constants, register indexes and shared struct types.
// No dependencies.
package arfp_pkg;

  localparam logic [7:0] Delim      = 8'h7E;
  localparam logic [7:0] ChkBase    = 8'hFF;
  localparam logic [7:0] GainReset  = 8'd10;
  localparam logic [7:0] CeilReset  = 8'd250;

  // byte position codes: hunting, then index of the next body byte
  localparam logic [4:0] PosHunt    = 5'd0;
  localparam logic [4:0] PosFirst   = 5'd1;
  localparam logic [4:0] PosType    = 5'd3;
  localparam logic [4:0] PosPayload = 5'd15;
  localparam logic [4:0] PosCheck   = 5'd16;

  // register indexes (paddr[2])
  localparam logic RegGain    = 1'b0;
  localparam logic RegCeiling = 1'b1;

  localparam logic StatusGood = 1'b0;
  localparam logic StatusBad  = 1'b1;

  typedef struct packed {
    logic [7:0] gain;
    logic [7:0] ceiling;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       status;
    logic [7:0] level;
  } res_t;

endpackage

### sv/arfp_rx_if.sv
// Input channel interface: one received serial byte per item.
// Valid/ready handshake; no dependencies.
interface arfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/arfp_res_if.sv
// Result channel interface: frame status and scaled level per item.
// Valid/ready handshake; no dependencies.
interface arfp_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] level;

  modport source (output valid, output status, output level, input ready);
  modport sink   (input valid, input status, input level, output ready);
endinterface

### sv/arfp_cfg_regs.sv
// APB-style configuration registers: gain and ceiling.
// Depends on arfp_pkg.
module arfp_cfg_regs import arfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain    <= GainReset;
      cfg.ceiling <= CeilReset;
    end else if (wr_en) begin
      if (paddr[2] == RegGain) begin
        cfg.gain <= pwdata[7:0];
      end else begin
        cfg.ceiling <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegCeiling) begin
      prdata = {24'd0, cfg.ceiling};
    end else begin
      prdata = {24'd0, cfg.gain};
    end
  end

endmodule

### sv/arfp_parser.sv
// Frame parser: delimiter hunt, body position count, running checksum,
// payload latch and the result computation on the checksum byte.
// Depends on arfp_pkg.
module arfp_parser import arfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       at_check,
  output res_t       res
);

  logic [4:0]  pos, pos_next;
  logic [7:0]  acc, acc_next;
  logic [7:0]  payload, payload_next;
  logic [15:0] prod;
  logic [7:0]  expect_sum;
  logic        hunting;

  assign hunting    = (pos == PosHunt) || (pos > PosCheck);
  assign at_check   = (pos == PosCheck);
  assign prod       = {8'd0, payload} * {8'd0, cfg.gain};
  assign expect_sum = ChkBase - acc;

  always_comb begin
    pos_next     = pos;
    acc_next     = acc;
    payload_next = payload;
    res.load     = 1'b0;
    res.status   = StatusGood;
    res.level    = 8'd0;
    if (accept) begin
      if (hunting) begin
        if (rx_byte == Delim) begin
          pos_next = PosFirst;
          acc_next = 8'd0;
        end else begin
          pos_next = PosHunt;
        end
      end else if (at_check) begin
        pos_next = PosHunt;
        res.load = 1'b1;
        if (rx_byte != expect_sum) begin
          res.status = StatusBad;
        end else if (prod > {8'd0, cfg.ceiling}) begin
          res.level = cfg.ceiling;
        end else begin
          res.level = prod[7:0];
        end
      end else begin
        // length bytes are skipped, the rest of the body is summed
        if (pos >= PosType && pos <= PosPayload) begin
          acc_next = acc + rx_byte;
        end
        if (pos == PosPayload) begin
          payload_next = rx_byte;
        end
        pos_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= PosHunt;
      acc     <= 8'd0;
      payload <= 8'd0;
    end else begin
      pos     <= pos_next;
      acc     <= acc_next;
      payload <= payload_next;
    end
  end

endmodule

### sv/arfp_out_reg.sv
// Result register: holds one finished item until the sink takes it.
// Depends on arfp_pkg.
module arfp_out_reg import arfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  res_t       res,
  input  logic       ready,
  output logic       valid,
  output logic       status,
  output logic [7:0] level,
  output logic       busy
);

  assign busy = valid && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status <= res.status;
      level  <= res.level;
    end
  end

endmodule

### sv/api_rx_frame_parser_core.sv
// API frame receive parser, top level.
// Throughput: one byte per cycle while the input is not stalled; the byte counter and checksum are registered.
// The result is valid in the cycle after the checksum byte is accepted.
// Input stalls only when the checksum byte waits and the result register is still held.
// Reset (rst, synchronous, active high): parser hunts for the delimiter, result
// register empty, gain = 10 and ceiling = 250.
module api_rx_frame_parser_core import arfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  arfp_rx_if.sink     rx,
  arfp_res_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  res_t res;
  logic at_check;
  logic busy;
  logic accept;

  assign rx.ready = !(at_check && busy);
  assign accept   = rx.valid && rx.ready;

  arfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx.rx_byte),
    .cfg      (cfg),
    .at_check (at_check),
    .res      (res)
  );

  arfp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .ready  (result.ready),
    .valid  (result.valid),
    .status (result.status),
    .level  (result.level),
    .busy   (busy)
  );

  // a new result never lands on one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.load |-> !busy)
    else $error("result register overwritten while held");

  // results come only from an accepted checksum byte
  a_load_on_check: assert property (@(posedge clk) disable iff (rst)
    res.load |-> (accept && at_check))
    else $error("result produced outside the checksum byte");

  a_valid_after_load: assert property (@(posedge clk) disable iff (rst)
    res.load |=> result.valid)
    else $error("loaded result not presented");

  // checksum byte always returns the parser to hunting
  a_back_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && at_check) |=> !at_check)
    else $error("parser stayed on checksum position");

endmodule

### dv/api_rx_frame_parser_core_test.sv
// Self-checking bench for api_rx_frame_parser_core: random and directed byte streams,
// an in-bench frame parser for expected results, APB register setup between phases.
// Depends on arfp_pkg, arfp_rx_if, arfp_res_if and api_rx_frame_parser_core.
`timescale 1ns / 100ps

module api_rx_frame_parser_core_test;
  import arfp_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic       status;
    logic [7:0] level;
  } level_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  arfp_rx_if  rx_ch ();
  arfp_res_if res_ch ();

  api_rx_frame_parser_core uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // parser shadow state and register copies
  logic [4:0]  frame_pos;
  logic [7:0]  frame_sum;
  logic [7:0]  frame_payload;
  logic [7:0]  cfg_gain;
  logic [7:0]  cfg_ceiling;

  logic [7:0]  rx_bytes_q[$];
  level_rec_t  levels_due[$];

  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_took;
  logic        hold_armed = 1'b0;
  logic        hold_done;
  int          hold_left;
  int          stuck_cycles;

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endfunction

  // advance the shadow parser by one byte; queue a result on the checksum byte
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [15:0] product;
    level_rec_t  rec;
    if (frame_pos == PosHunt || frame_pos > PosCheck) begin
      if (b == Delim) begin
        frame_pos = PosFirst;
        frame_sum = 8'd0;
      end else begin
        frame_pos = PosHunt;
      end
    end else if (frame_pos == PosCheck) begin
      frame_pos = PosHunt;
      if (b != 8'(ChkBase - frame_sum)) begin
        rec.status = StatusBad;
        rec.level  = 8'd0;
      end else begin
        product    = 16'(frame_payload) * 16'(cfg_gain);
        rec.status = StatusGood;
        rec.level  = (product > 16'(cfg_ceiling)) ? cfg_ceiling : product[7:0];
      end
      levels_due.push_back(rec);
    end else begin
      if (frame_pos >= PosType && frame_pos <= PosPayload) begin
        frame_sum = frame_sum + b;
        if (frame_pos == PosPayload) frame_payload = b;
      end
      frame_pos = frame_pos + 5'd1;
    end
  endfunction

  // fields: type, 8 long address, 2 short address, options, payload
  task automatic queue_frame(input logic [7:0] fields [13], input bit bad_sum, input int cut);
    logic [7:0] frame [17];
    logic [7:0] sum;
    sum = 8'd0;
    frame[0] = Delim;
    frame[1] = 8'($urandom);
    frame[2] = 8'($urandom);
    for (int i = 0; i < 13; i++) begin
      frame[3 + i] = fields[i];
      sum = sum + fields[i];
    end
    frame[16] = ChkBase - sum;
    if (bad_sum) frame[16] = frame[16] ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < 17 - cut; i++) rx_bytes_q.push_back(frame[i]);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    // read back straight after the write
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value)
      log_mismatch($sformatf("reg %0d readback exp %0d got %0d", idx, value, prdata[7:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegGain) cfg_gain = value;
    else cfg_ceiling = value;
  endtask

  // queue random traffic, then wait until the block has drained
  task automatic run_phase(input int n_items, input int tx_idle, input int rx_idle);
    logic [7:0] fields [13];
    logic [7:0] noise;
    int         sent;
    int         cut;
    tx_idle_pct = tx_idle;
    rx_idle_pct = rx_idle;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(2, 0)) begin
        noise = 8'($urandom);
        if (noise == Delim && $urandom_range(9, 0) != 0) noise = ~noise;
        rx_bytes_q.push_back(noise);
      end
      for (int i = 0; i < 13; i++) fields[i] = 8'($urandom);
      cut = ($urandom_range(99, 0) < 8) ? $urandom_range(15, 1) : 0;
      queue_frame(fields, $urandom_range(99, 0) < 25, cut);
      sent += 17 - cut;
    end
    do @(posedge clk);
    while (rx_bytes_q.size() != 0 || rx_ch.valid || levels_due.size() != 0);
    // let a trailing byte that gives no result settle before touching registers
    repeat (4) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'd0;
    end else if (!rx_ch.valid || rx_took) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= rx_bytes_q.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off when armed
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HoldCycles;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // monitor: check results first, then predict from the accepted byte
  always @(posedge clk) begin : mon
    level_rec_t due;
    if (rst) begin
      rx_took <= 1'b0;
    end else begin
      rx_took <= rx_ch.valid && rx_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (levels_due.size() == 0) begin
          log_mismatch($sformatf("unexpected item status %0d level %0d",
                                 res_ch.status, res_ch.level));
        end else begin
          due = levels_due.pop_front();
          if (res_ch.status !== due.status)
            log_mismatch($sformatf("status exp %0d got %0d", due.status, res_ch.status));
          if (res_ch.level !== due.level)
            log_mismatch($sformatf("level exp %0d got %0d", due.level, res_ch.level));
        end
      end
      if (rx_ch.valid && rx_ch.ready) parse_rx_byte(rx_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    res_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    frame_pos     = PosHunt;
    frame_sum     = 8'd0;
    frame_payload = 8'd0;
    cfg_gain      = GainReset;
    cfg_ceiling   = CeilReset;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: dropped bytes while hunting, delimiter inside the body,
    // payload that clamps against the reset ceiling
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h81);
    queue_frame('{8'h00, 8'h7E, 8'hFF, 8'h01, 8'h80, 8'h7E, 8'h55, 8'hAA, 8'h00,
                  8'h7E, 8'hFF, 8'h7E, 8'hFF}, 1'b0, 0);
    run_phase(0, 14, 55);

    write_reg(RegGain, 8'd1);
    write_reg(RegCeiling, 8'd255);
    run_phase(500, 14, 55);

    write_reg(RegGain, 8'd255);
    write_reg(RegCeiling, 8'($urandom_range(254, 1)));
    run_phase(500, 55, 14);

    write_reg(RegGain, 8'($urandom_range(12, 2)));
    write_reg(RegCeiling, 8'($urandom_range(255, 0)));
    hold_armed = 1'b1;
    run_phase(700, 0, 0);

    write_reg(RegGain, 8'd0);
    write_reg(RegCeiling, 8'd0);
    run_phase(200, 0, 0);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
